[design/lbp_pkg.sv]
// Shared types, constants and helpers for the 3x3 local binary pattern coder.
package lbp_pkg;

   // Line store geometry.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // Field widths.
   localparam int PIXEL_W = 8;
   localparam int DIM_W   = 11;
   localparam int CODE_W  = 8;
   localparam int CSR_IDX_W = 2;

   // Register reset values and legal range.
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
   localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);
   localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1
   } lbp_reg_type;

   // One result as it travels through the output queue.
   typedef struct packed {
      logic [CODE_W-1:0] pattern_code;
      logic              frame_last;
   } lbp_rsp_type;

   // Saturate a written dimension into [3, hi].
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v < DIM_MIN) begin
         r = DIM_MIN;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[design/lbp_line_ram.sv]
// Simple dual-port synchronous RAM with a registered read port.
module lbp_line_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; a read of the address being written returns the old data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/lbp_window.sv]
// 3x3 pixel window and the comparison logic that forms the pattern code.
module lbp_window
   import lbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  logic [PIXEL_W-1:0] top_px,
   input  logic [PIXEL_W-1:0] mid_px,
   input  logic [PIXEL_W-1:0] bot_px,
   output logic [CODE_W-1:0]  pattern_code
);

   logic [3*PIXEL_W-1:0] top_row_ff, top_row_in;
   logic [3*PIXEL_W-1:0] mid_row_ff, mid_row_in;
   logic [3*PIXEL_W-1:0] bot_row_ff, bot_row_in;
   logic [PIXEL_W-1:0]   center;

   // Shift the new column in; the oldest column sits in the top byte.
   always_comb begin
      top_row_in = {top_row_ff[2*PIXEL_W-1:0], top_px};
      mid_row_in = {mid_row_ff[2*PIXEL_W-1:0], mid_px};
      bot_row_in = {bot_row_ff[2*PIXEL_W-1:0], bot_px};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_row_ff <= '0;
         mid_row_ff <= '0;
         bot_row_ff <= '0;
      end else if (shift_en) begin
         top_row_ff <= top_row_in;
         mid_row_ff <= mid_row_in;
         bot_row_ff <= bot_row_in;
      end
   end

   // Compare the center against its eight neighbors, clockwise from top-left.
   always_comb begin
      center = mid_row_in[2*PIXEL_W-1:PIXEL_W];
      pattern_code[0] = center <= top_row_in[3*PIXEL_W-1:2*PIXEL_W];
      pattern_code[1] = center <= top_row_in[2*PIXEL_W-1:PIXEL_W];
      pattern_code[2] = center <= top_row_in[PIXEL_W-1:0];
      pattern_code[3] = center <= mid_row_in[PIXEL_W-1:0];
      pattern_code[4] = center <= bot_row_in[PIXEL_W-1:0];
      pattern_code[5] = center <= bot_row_in[2*PIXEL_W-1:PIXEL_W];
      pattern_code[6] = center <= bot_row_in[3*PIXEL_W-1:2*PIXEL_W];
      pattern_code[7] = center <= mid_row_in[3*PIXEL_W-1:2*PIXEL_W];
   end

endmodule

[design/lbp_rsp_fifo.sv]
// Three-entry result queue between the window logic and the response port.
module lbp_rsp_fifo
   import lbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  lbp_rsp_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output lbp_rsp_type pop_data,
   output logic [1:0]  count
);

   localparam logic [1:0] LAST_SLOT = 2'd2;

   lbp_rsp_type  slot_ff [3];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = count_ff != 2'd0;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   // Pointer and fill bookkeeping, pointers wrap after the third slot.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/lbp_3x3_pixel_coder.sv]
// Top level of the 3x3 local binary pattern coder.
// The coder takes one grayscale pixel per clock in raster order while request ready
// is high and returns one 8-bit pattern code for each interior pixel after the pixel
// below and to the right of it is accepted; border pixels give no response. Both line
// stores share one 1024 x 16 RAM with one read and one write port: each pixel reads
// its column in the cycle it is accepted and writes the column back in the next,
// with a bypass when the following request hits the same column, so the sustained
// rate is one pixel per cycle. A three-entry response queue lets requests keep
// flowing while a response waits; request ready drops only when that queue and the
// pixel in flight could fill it. The line stores are not cleared after reset: the
// first two rows of each frame fill them before any code depends on them.
// Width and height are saturated to [3, 1024] on write and should only be changed
// while the coder is idle.
module lbp_3x3_pixel_coder
   import lbp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIXEL_W-1:0]   req_pixel_value,
   input  logic                 req_frame_start,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CODE_W-1:0]    rsp_pattern_code,
   output logic                 rsp_frame_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_write_data
);

   // Configuration.
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;

   // Raster position of the next pixel.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Pixel in flight while its line store read returns.
   logic               s1_valid_ff;
   logic [COL_W-1:0]   s1_addr_ff;
   logic [PIXEL_W-1:0] s1_px_ff;
   logic               s1_emit_ff;
   logic               s1_last_ff;
   logic               fwd_ff, fwd_in;
   logic [PIXEL_W-1:0] fwd_top_ff, fwd_mid_ff;

   logic               accept;
   logic [COL_W-1:0]   cur_col;
   logic [ROW_W-1:0]   cur_row;
   logic [DIM_W-1:0]   col_ext, row_ext, col_next, row_next;
   logic               emit_in, last_in;
   logic [2*PIXEL_W-1:0] rd_data;
   logic [PIXEL_W-1:0] eff_top, eff_mid;
   logic [CODE_W-1:0]  code;
   lbp_rsp_type        push_data, pop_data;
   logic [1:0]         fifo_count;
   logic [2:0]         pending;

   assign csr_ready = 1'b1;

   // Register writes; values are saturated on the way in.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = clamp_dim(csr_write_data, WIDTH_MAX);
            REG_IMAGE_HEIGHT: height_in = clamp_dim(csr_write_data, HEIGHT_MAX);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Flow control: the queue plus the pixel in flight must leave room for one more.
   assign pending   = {1'b0, fifo_count} + {2'b00, s1_valid_ff && s1_emit_ff};
   assign req_ready = pending <= 3'd2;
   assign accept    = req_valid && req_ready;

   // Position of the incoming pixel and where the following one lands.
   always_comb begin
      cur_col  = req_frame_start ? '0 : col_ff;
      cur_row  = req_frame_start ? '0 : row_ff;
      col_ext  = {{(DIM_W-COL_W){1'b0}}, cur_col};
      row_ext  = {{(DIM_W-ROW_W){1'b0}}, cur_row};
      emit_in  = (row_ext >= DIM_W'(2)) && (col_ext >= DIM_W'(2));
      last_in  = (row_ext == height_ff - DIM_W'(1)) && (col_ext == width_ff - DIM_W'(1));
      col_next = col_ext + DIM_W'(1);
      row_next = row_ext;
      if (col_next >= width_ff) begin
         col_next = '0;
         row_next = row_ext + DIM_W'(1);
      end
      if (row_next >= height_ff) begin
         row_next = '0;
      end
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = col_next[COL_W-1:0];
         row_in = row_next[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store data for the pixel in flight, bypassed when the previous pixel
   // wrote the same column in the cycle this one was read.
   assign eff_top = fwd_ff ? fwd_top_ff : rd_data[2*PIXEL_W-1:PIXEL_W];
   assign eff_mid = fwd_ff ? fwd_mid_ff : rd_data[PIXEL_W-1:0];
   assign fwd_in  = s1_valid_ff && (s1_addr_ff == cur_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= cur_col;
         s1_px_ff   <= req_pixel_value;
         s1_emit_ff <= emit_in;
         s1_last_ff <= last_in;
         fwd_ff     <= fwd_in;
         fwd_top_ff <= eff_mid;
         fwd_mid_ff <= s1_px_ff;
      end
   end

   // Both line stores in one RAM: upper store in the high byte, middle in the low.
   lbp_line_ram #(
      .WIDTH (2*PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data ({eff_mid, s1_px_ff}),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (rd_data)
   );

   // Window shift and code.
   lbp_window u_window (
      .clock        (clock),
      .reset        (reset),
      .shift_en     (s1_valid_ff),
      .top_px       (eff_top),
      .mid_px       (eff_mid),
      .bot_px       (s1_px_ff),
      .pattern_code (code)
   );

   // Response queue.
   assign push_data.pattern_code = code;
   assign push_data.frame_last   = s1_last_ff;

   lbp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff && s1_emit_ff),
      .push_data (push_data),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (pop_data),
      .count     (fifo_count)
   );

   assign rsp_pattern_code = pop_data.pattern_code;
   assign rsp_frame_last   = pop_data.frame_last;

endmodule

[tb/sv/lbp_3x3_pixel_coder_test.sv]
// Self-checking testbench for the 3x3 local binary pattern coder.
`timescale 1ns / 100ps

module lbp_3x3_pixel_coder_test;
   import lbp_pkg::*;

   localparam int CLOCK_HALF    = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int LINE_DEPTH    = 1024;
   localparam int HEIGHT_LIMIT  = 1024;
   localparam int DIM_FLOOR     = 3;
   localparam int START_WIDTH   = 640;
   localparam int START_HEIGHT  = 480;

   // Block inputs start at known values.
   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [PIXEL_W-1:0]   req_pixel_value  = '0;
   logic                 req_frame_start  = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [CODE_W-1:0]    rsp_pattern_code;
   logic                 rsp_frame_last;
   logic                 csr_valid        = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [DIM_W-1:0]     csr_write_data   = '0;

   // Idling controls shared by the request driver and the response stall driver.
   int unsigned sender_gap_pct     = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned mismatch_count     = 0;
   int unsigned cycle_count        = 0;

   // Shadow copy of the coder: configuration, line stores, window and position.
   logic [DIM_W-1:0]   shadow_width  = DIM_W'(START_WIDTH);
   logic [DIM_W-1:0]   shadow_height = DIM_W'(START_HEIGHT);
   logic [PIXEL_W-1:0] upper_pixels  [LINE_DEPTH];
   logic [PIXEL_W-1:0] middle_pixels [LINE_DEPTH];
   logic [23:0]        win_top = '0;
   logic [23:0]        win_mid = '0;
   logic [23:0]        win_bot = '0;
   int unsigned        col_pos = 0;
   int unsigned        row_pos = 0;

   // Codes predicted but not yet returned, oldest first.
   lbp_rsp_type pending_codes [$];

   lbp_3x3_pixel_coder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pattern_code (rsp_pattern_code),
      .rsp_frame_last   (rsp_frame_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Free-running clock.
   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Watchdog: a stuck handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Count every mismatch, but only print the first few.
   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch: %s", msg);
      end
   endtask

   // Saturate a written dimension into the range the coder actually uses.
   function automatic int unsigned saturate_dim(input logic [DIM_W-1:0] v,
                                                input int unsigned hi);
      if (v < DIM_FLOOR) begin
         return DIM_FLOOR;
      end
      if (v > hi) begin
         return hi;
      end
      return 32'(v);
   endfunction

   // Mix of full-range values, near-equal values and the two extremes.
   function automatic logic [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(3))
         0: return PIXEL_W'($urandom_range(136, 120));
         1: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         default: return PIXEL_W'($urandom_range(255));
      endcase
   endfunction

   // Advance the shadow coder by one accepted pixel and queue any code it yields.
   task automatic predict_code(input logic [PIXEL_W-1:0] pixel, input logic restart);
      int unsigned        w;
      int unsigned        h;
      int unsigned        col;
      int unsigned        row;
      logic [PIXEL_W-1:0] from_upper;
      logic [PIXEL_W-1:0] from_middle;
      logic [PIXEL_W-1:0] ctr;
      lbp_rsp_type        code;
      w = saturate_dim(shadow_width, LINE_DEPTH);
      h = saturate_dim(shadow_height, HEIGHT_LIMIT);
      if (restart) begin
         col_pos = 0;
         row_pos = 0;
      end
      col = col_pos;
      row = row_pos;
      if (col >= LINE_DEPTH) begin
         col = 0;
      end

      // Line stores shift down one row in this column.
      from_upper  = upper_pixels[col];
      from_middle = middle_pixels[col];
      upper_pixels[col]  = from_middle;
      middle_pixels[col] = pixel;
      win_top = {win_top[15:0], from_upper};
      win_mid = {win_mid[15:0], from_middle};
      win_bot = {win_bot[15:0], pixel};

      // Interior pixel: bit 0 top-left, clockwise to bit 7 left.
      if (row >= 2 && col >= 2) begin
         ctr = win_mid[15:8];
         code.pattern_code = {ctr <= win_mid[23:16], ctr <= win_bot[23:16],
                              ctr <= win_bot[15:8],  ctr <= win_bot[7:0],
                              ctr <= win_mid[7:0],   ctr <= win_top[7:0],
                              ctr <= win_top[15:8],  ctr <= win_top[23:16]};
         code.frame_last = (row == h - 1) && (col == w - 1);
         pending_codes.insert(pending_codes.size(), code);
      end

      // Raster position, wrapping at the frame end.
      col++;
      if (col >= w) begin
         col = 0;
         row++;
      end
      if (row >= h) begin
         row = 0;
      end
      col_pos = col;
      row_pos = row;
   endtask

   // Send one pixel request, with a random gap first when the sender idles.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic restart);
      if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < sender_gap_pct);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pixel;
      req_frame_start <= restart;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predict_code(pixel, restart);
   endtask

   // Stop sending and let every expected code come back, then a short pause.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one dimension register while the coder is idle.
   task automatic write_register(input lbp_reg_type idx, input logic [DIM_W-1:0] value);
      wait_for_idle();
      csr_valid      <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) begin
         shadow_width = value;
      end else begin
         shadow_height = value;
      end
   endtask

   task automatic set_idling(input int unsigned gap_pct, input int unsigned stall_pct);
      sender_gap_pct     = gap_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // A run of random pixels, optionally opening with a frame start.
   task automatic send_random_run(input int unsigned count, input logic open_frame);
      for (int unsigned k = 0; k < count; k++) begin
         send_pixel(random_pixel(), open_frame && k == 0);
      end
   endtask

   // Mostly whole frames with random content; some cut short, some restarted
   // mid-frame, some continuing without a frame start.
   task automatic run_random_frames(input int unsigned budget);
      int unsigned sent;
      int unsigned frame_px;
      int unsigned count;
      logic        restart;
      logic        first;
      sent  = 0;
      first = 1'b1;
      while (sent < budget) begin
         frame_px = saturate_dim(shadow_width, LINE_DEPTH) *
                    saturate_dim(shadow_height, HEIGHT_LIMIT);
         if ($urandom_range(9) < 2) begin
            count = $urandom_range(frame_px - 1, 1);
         end else begin
            count = frame_px;
         end
         for (int unsigned k = 0; k < count; k++) begin
            restart = (k == 0) && (first || $urandom_range(3) != 0);
            if (k != 0 && $urandom_range(199) == 0) begin
               restart = 1'b1;
            end
            send_pixel(random_pixel(), restart);
         end
         sent += count;
         first = 1'b0;
      end
   endtask

   // Reset dimensions: two full rows of 640 and a few pixels of the third.
   task automatic test_reset_dimensions();
      set_idling(0, 0);
      send_random_run(2 * START_WIDTH + 6, 1'b1);
   endtask

   // Hand-picked 3x3 frames: equal, lower and higher neighbors, an all-ones code
   // and a single-bit code, wrap without a frame start, and a restart mid-frame.
   task automatic test_directed_patterns();
      logic [PIXEL_W-1:0] pixels [29] = '{
         8'd99,  8'd100, 8'd101, 8'd255, 8'd100, 8'd0,   8'd50,  8'd100, 8'd200,
         8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
         8'd7,   8'd200,
         8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd255};
      set_idling(0, 0);
      write_register(REG_IMAGE_WIDTH, 11'd3);
      write_register(REG_IMAGE_HEIGHT, 11'd3);
      for (int k = 0; k < 29; k++) begin
         send_pixel(pixels[k], k == 0 || k == 20);
      end
   endtask

   // Dimensions written above the ceiling and below the floor.
   task automatic test_dimension_extremes();
      // A width past the ceiling keeps the first row long enough to give no codes.
      write_register(REG_IMAGE_WIDTH, 11'd2047);
      write_register(REG_IMAGE_HEIGHT, 11'd3);
      set_idling(26, 26);
      send_random_run(40, 1'b1);

      write_register(REG_IMAGE_WIDTH, 11'd0);
      write_register(REG_IMAGE_HEIGHT, 11'd2047);
      set_idling(50, 0);
      send_random_run(30, 1'b1);

      write_register(REG_IMAGE_WIDTH, 11'd2);
      write_register(REG_IMAGE_HEIGHT, 11'd1);
      set_idling(0, 50);
      send_random_run(18, 1'b1);
   endtask

   // Random small frames under each idling mix.
   task automatic test_random_traffic();
      int unsigned gap_pct   [4] = '{0, 50, 0, 26};
      int unsigned stall_pct [4] = '{0, 0, 50, 26};
      for (int p = 0; p < 4; p++) begin
         for (int c = 0; c < 4; c++) begin
            write_register(REG_IMAGE_WIDTH, DIM_W'($urandom_range(12, 0)));
            write_register(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(8, 0)));
            set_idling(gap_pct[p], stall_pct[p]);
            run_random_frames(30);
         end
      end
   endtask

   // Response stall driver.
   always @(posedge clock) begin
      if (receiver_stall_pct == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Compare each accepted response with the oldest predicted code.
   always @(posedge clock) begin
      lbp_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            flag_error($sformatf("response with nothing expected: code=%02h last=%0b",
                                 rsp_pattern_code, rsp_frame_last));
         end else begin
            want = pending_codes.pop_front();
            if (rsp_pattern_code !== want.pattern_code) begin
               flag_error($sformatf("pattern_code expected %02h got %02h",
                                    want.pattern_code, rsp_pattern_code));
            end
            if (rsp_frame_last !== want.frame_last) begin
               flag_error($sformatf("frame_last expected %0b got %0b",
                                    want.frame_last, rsp_frame_last));
            end
         end
      end
   end

   // Test sequence.
   initial begin
      for (int k = 0; k < LINE_DEPTH; k++) begin
         upper_pixels[k]  = '0;
         middle_pixels[k] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_dimensions();
      test_directed_patterns();
      test_dimension_extremes();
      test_random_traffic();
      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
